@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk_i, held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ src/jse_pkg.sv @@
// ----------------------------------------------------------------------------
// jse_pkg
// shared types, codes and constants of the jog/shuttle event decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jse_pkg;

  localparam int unsigned KEY_COUNT   = 15;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] TICKS_MAX   = 16'hffff;
  localparam logic [4:0]  SHUTTLE_MID = 5'd7;

  typedef enum logic [1:0] {
    CMD_KEY     = 2'd0,
    CMD_JOG     = 2'd1,
    CMD_SHUTTLE = 2'd2,
    CMD_TICK    = 2'd3
  } jse_cmd_e;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_SHUTTLE = 2'd2,
    KIND_JOG     = 2'd3
  } jse_kind_e;

  typedef struct packed {
    jse_kind_e   event_kind;
    logic [4:0]  action_index;
    logic [7:0]  repeat_count;
    logic        last_of_run;
  } jse_result_t;

  typedef struct packed {
    logic [1:0]        count;
    jse_result_t [1:0] res;
  } jse_push_t;

  function automatic jse_result_t make_result(jse_kind_e kind, logic [4:0] idx,
                                              logic [7:0] rep, logic last);
    jse_result_t r;
    r.event_kind   = kind;
    r.action_index = idx;
    r.repeat_count = rep;
    r.last_of_run  = last;
    return r;
  endfunction

endpackage

@@ src/jse_in_if.sv @@
// ----------------------------------------------------------------------------
// jse_in_if
// event item channel: valid/ready handshake with the event fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jse_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [4:0]        key_index;
  logic              key_pressed;
  logic [7:0]        jog_pos;
  logic signed [3:0] shuttle_pos;

  modport source (
    output valid, cmd, key_index, key_pressed, jog_pos, shuttle_pos,
    input  ready
  );

  modport sink (
    input  valid, cmd, key_index, key_pressed, jog_pos, shuttle_pos,
    output ready
  );
endinterface

@@ src/jse_out_if.sv @@
// ----------------------------------------------------------------------------
// jse_out_if
// action item channel: valid/ready handshake with the action fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [4:0] action_index;
  logic [7:0] repeat_count;
  logic       last_of_run;

  modport source (
    output valid, event_kind, action_index, repeat_count, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, event_kind, action_index, repeat_count, last_of_run,
    output ready
  );
endinterface

@@ src/jse_decode.sv @@
// ----------------------------------------------------------------------------
// jse_decode
// event decode and wheel state: turns one accepted event into up to two actions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               accept_i,
  input  logic [1:0]         cmd_i,
  input  logic [4:0]         key_index_i,
  input  logic               key_pressed_i,
  input  logic [7:0]         jog_pos_i,
  input  logic signed [3:0]  shuttle_pos_i,
  output jse_pkg::jse_push_t push_o
);
  import jse_pkg::*;

  logic [15:0]       timeout_q, timeout_d;
  logic [7:0]        prev_jog_q, prev_jog_d;
  logic              jog_known_q, jog_known_d;
  logic signed [3:0] prev_shuttle_q, prev_shuttle_d;
  logic              pending_q, pending_d;
  logic [15:0]       ticks_q, ticks_d;

  logic [7:0]  jog_diff;
  logic [8:0]  jog_steps;
  logic [8:0]  jog_net;
  logic        jog_hit0;
  logic        jog_up;
  logic        jog_fire;
  logic        ret_fire;
  logic        ret_emit;
  logic [2:0]  shut_mag;
  jse_result_t jog_res;
  jse_result_t ret_res;

  // closed-form step count over the 8-bit wheel, skipping the step off zero
  always_comb begin
    jog_diff = 8'(jog_pos_i - prev_jog_q);
    jog_up   = !jog_diff[7];
    if (jog_diff[7]) begin
      jog_steps = 9'd256 - {1'b0, jog_diff};
      jog_hit0  = {1'b0, prev_jog_q} < jog_steps;
    end else begin
      jog_steps = {1'b0, jog_diff};
      jog_hit0  = {1'b0, 8'(8'd0 - prev_jog_q)} < jog_steps;
    end
    jog_net  = jog_steps - 9'(jog_hit0);
    jog_fire = jog_known_q && (jog_pos_i != prev_jog_q) && (jog_net != 9'd0);
    ret_fire = pending_q && (ticks_q >= timeout_q);
    ret_emit = ret_fire && (prev_shuttle_q != 4'sd0);
    shut_mag = shuttle_pos_i[3] ? 3'(4'sd0 - shuttle_pos_i) : shuttle_pos_i[2:0];
    jog_res  = make_result(KIND_JOG, {4'd0, jog_up}, jog_net[7:0], 1'b1);
    ret_res  = make_result(KIND_SHUTTLE, SHUTTLE_MID, 8'd1, !jog_fire);
  end

  always_comb begin
    timeout_d      = cfg_we_i ? cfg_wdata_i : timeout_q;
    prev_jog_d     = prev_jog_q;
    jog_known_d    = jog_known_q;
    prev_shuttle_d = prev_shuttle_q;
    pending_d      = pending_q;
    ticks_d        = ticks_q;
    push_o         = '0;
    if (accept_i) begin
      unique case (jse_cmd_e'(cmd_i))
        CMD_KEY: begin
          if ({1'b0, key_index_i} < 6'(KEY_COUNT)) begin
            push_o.count  = 2'd1;
            push_o.res[0] = make_result(key_pressed_i ? KIND_PRESS : KIND_RELEASE,
                                        key_index_i, 8'd1, 1'b1);
          end
        end
        CMD_SHUTTLE: begin
          if (shuttle_pos_i != -4'sd8) begin
            ticks_d        = '0;
            pending_d      = (shuttle_pos_i != 4'sd0);
            prev_shuttle_d = shuttle_pos_i;
            if (prev_shuttle_q < shuttle_pos_i) begin
              push_o.count  = 2'd1;
              push_o.res[0] = make_result(KIND_SHUTTLE, SHUTTLE_MID + {2'd0, shut_mag},
                                          8'd1, 1'b1);
            end else if (prev_shuttle_q > shuttle_pos_i) begin
              push_o.count  = 2'd1;
              push_o.res[0] = make_result(KIND_SHUTTLE, SHUTTLE_MID - {2'd0, shut_mag},
                                          8'd1, 1'b1);
            end
          end
        end
        CMD_TICK: begin
          if (ticks_q != TICKS_MAX) begin
            ticks_d = ticks_q + 16'd1;
          end
        end
        CMD_JOG: begin
          if (ret_fire) begin
            ticks_d        = '0;
            pending_d      = 1'b0;
            prev_shuttle_d = 4'sd0;
          end
          if (ret_emit && jog_fire) begin
            push_o.count  = 2'd2;
            push_o.res[0] = ret_res;
            push_o.res[1] = jog_res;
          end else if (ret_emit) begin
            push_o.count  = 2'd1;
            push_o.res[0] = ret_res;
          end else if (jog_fire) begin
            push_o.count  = 2'd1;
            push_o.res[0] = jog_res;
          end
          prev_jog_d  = jog_pos_i;
          jog_known_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q      <= TIMEOUT_RST;
      prev_jog_q     <= '0;
      jog_known_q    <= 1'b0;
      prev_shuttle_q <= '0;
      pending_q      <= 1'b0;
      ticks_q        <= '0;
    end else begin
      timeout_q      <= timeout_d;
      prev_jog_q     <= prev_jog_d;
      jog_known_q    <= jog_known_d;
      prev_shuttle_q <= prev_shuttle_d;
      pending_q      <= pending_d;
      ticks_q        <= ticks_d;
    end
  end

endmodule

@@ src/jse_queue.sv @@
// ----------------------------------------------------------------------------
// jse_queue
// action result queue: takes up to two items a cycle, hands out one a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  jse_pkg::jse_push_t    push_i,
  input  logic                  pop_i,
  output logic [jse_pkg::LEVEL_W-1:0] level_o,
  output jse_pkg::jse_result_t  head_o
);
  import jse_pkg::*;

  jse_result_t [QUEUE_DEPTH-1:0] mem_q;
  logic [PTR_W-1:0]   wptr_q, wptr_d;
  logic [PTR_W-1:0]   rptr_q, rptr_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [PTR_W-1:0]   wptr_next;

  always_comb begin
    wptr_next = wptr_q + PTR_W'(1);
    wptr_d    = wptr_q + PTR_W'(push_i.count);
    rptr_d    = pop_i ? rptr_q + PTR_W'(1) : rptr_q;
    level_d   = level_q + LEVEL_W'(push_i.count) - LEVEL_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.res[0];
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_next] <= push_i.res[1];
    end
  end

  assign level_o = level_q;
  assign head_o  = mem_q[rptr_q];

endmodule

@@ src/jog_shuttle_event_decoder.sv @@
// jog_shuttle_event_decoder: control-wheel events in, action items out
// ordering: the actions of an accepted event are registered in the queue, offered in order
// throughput: one event per cycle while the queue holds at most two actions; output
//   drains one action per cycle when ready, a shuttle return before its jog steps
// reset: wheel state cleared, return timeout set to 5000 ticks, result queue empty
`timescale 1ns / 1ps
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// jog_shuttle_event_decoder
// decodes key, jog, shuttle and tick events into action items through a queue
// ----------------------------------------------------------------------------
module jog_shuttle_event_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  jse_in_if.sink      in_i,
  jse_out_if.source   out_o
);
  import jse_pkg::*;

  logic               accept;
  logic               pop;
  logic [LEVEL_W-1:0] level;
  jse_push_t          push;
  jse_result_t        head;
  logic               pair_ok;

  assign in_i.ready = (level <= LEVEL_W'(QUEUE_DEPTH - 2));
  assign accept     = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  jse_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .cmd_i         (in_i.cmd),
    .key_index_i   (in_i.key_index),
    .key_pressed_i (in_i.key_pressed),
    .jog_pos_i     (in_i.jog_pos),
    .shuttle_pos_i (in_i.shuttle_pos),
    .push_o        (push)
  );

  jse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .level_o (level),
    .head_o  (head)
  );

  assign out_o.valid        = (level != '0);
  assign out_o.event_kind   = head.event_kind;
  assign out_o.action_index = head.action_index;
  assign out_o.repeat_count = head.repeat_count;
  assign out_o.last_of_run  = head.last_of_run;

  // shuttle return first, then jog steps
  assign pair_ok = (push.res[0].event_kind == KIND_SHUTTLE) &&
                   (push.res[1].event_kind == KIND_JOG) && !push.res[0].last_of_run;

  `ASSERT_ALWAYS(a_level_bound, level <= LEVEL_W'(QUEUE_DEPTH))
  `ASSERT_IMPLIES(a_push_only_on_accept, push.count != 2'd0, accept)
  `ASSERT_IMPLIES(a_pair_order, push.count == 2'd2, pair_ok)
  `ASSERT_NEXT(a_push_shows, push.count != 2'd0, out_o.valid)

endmodule
